[sv/prpg_pkg.sv]
// Shared types and constants of the partial random permutation generator.
`timescale 1ns / 1ps

package prpg_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int VAL_W       = 10;
    localparam int LEN_W       = 11;
    localparam int RND_W       = 16;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 11;

    // Operation codes of an input item
    localparam logic [1:0] OP_BEGIN   = 2'd0;
    localparam logic [1:0] OP_SHUFFLE = 2'd1;
    localparam logic [1:0] OP_READ    = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PERM_LENGTH    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PARTIAL_COUNT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PARTIAL_ENABLE = 2'd2;

    typedef struct packed {
        logic [1:0]       operation;
        logic [RND_W-1:0] random_value;
        logic [9:0]       read_index;
    } in_item_t;

    typedef struct packed {
        logic [VAL_W-1:0] entry_value;
        logic             shuffle_done;
    } out_item_t;

endpackage

[sv/prpg_mod.sv]
// Bit-serial restoring remainder unit: random word modulo table length.
`timescale 1ns / 1ps

module prpg_mod (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [prpg_pkg::RND_W-1:0] dividend,
    input  logic [prpg_pkg::LEN_W-1:0] divisor,
    output logic                       done,
    output logic [prpg_pkg::VAL_W-1:0] remainder
);

    localparam int CNT_W = $clog2(prpg_pkg::RND_W + 1);

    logic [prpg_pkg::VAL_W-1:0] rem_reg, rem_next;
    logic [prpg_pkg::RND_W-1:0] dv_reg;
    logic [prpg_pkg::LEN_W-1:0] dsr_reg;
    logic [CNT_W-1:0]           cnt_reg;
    logic                       busy_reg, done_reg;
    logic [prpg_pkg::LEN_W-1:0] trial;

    // Shift in one dividend bit and subtract when it fits
    always_comb begin
        trial = {rem_reg, dv_reg[prpg_pkg::RND_W-1]};
        if (trial >= dsr_reg) begin
            rem_next = prpg_pkg::VAL_W'(trial - dsr_reg);
        end else begin
            rem_next = prpg_pkg::VAL_W'(trial);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(prpg_pkg::RND_W);
                rem_reg  <= '0;
                dv_reg   <= dividend;
                dsr_reg  <= divisor;
            end else if (busy_reg) begin
                rem_reg <= rem_next;
                dv_reg  <= {dv_reg[prpg_pkg::RND_W-2:0], 1'b0};
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

[sv/partial_random_permutation_gen_core.sv]
// Top level: permutation table, shuffle sequencer and partial finalization.
//
//  channel | ports                           | direction
//  --------+---------------------------------+----------
//  input   | s_valid s_ready s_data          | in
//  result  | m_valid m_ready m_data          | out
//  config  | cfg_valid cfg_ready cfg_index   | in
//          | cfg_data                        |
//
// A swap step runs the modulo unit, then two reads and two writes of the table. Begin
// writes the identity over the length. With partial mode the last shuffle adds a save of
// the prefix, an identity pass and a scatter pass over all 1024 positions.
// After reset a clearing pass zeroes all 1024 mark entries; no item is taken then.
// The next item is taken while the previous result still waits on m_ready.
`timescale 1ns / 1ps

module partial_random_permutation_gen_core (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  prpg_pkg::in_item_t              s_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output prpg_pkg::out_item_t             m_data,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [prpg_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [prpg_pkg::CFG_DATA_W-1:0] cfg_data
);

    localparam int DEPTH = prpg_pkg::TABLE_DEPTH;
    localparam int IW    = prpg_pkg::IDX_W;
    localparam int VW    = prpg_pkg::VAL_W;
    localparam int LW    = prpg_pkg::LEN_W;

    typedef enum logic [3:0] {
        ST_CLR, ST_IDLE, ST_ID, ST_DIV, ST_SWRD, ST_SWWA, ST_SWWB, ST_CHK,
        ST_FIN, ST_SAVE, ST_SCRD, ST_SCWR, ST_RDW, ST_RESP
    } state_t;

    state_t state_reg;

    // Memories
    logic [VW-1:0] table_mem [DEPTH];
    logic [VW-1:0] saved_mem [DEPTH];
    logic          marks_mem [DEPTH];

    // Configuration
    logic [LW-1:0] len_reg, pcnt_reg;
    logic          pen_reg;

    logic [LW-1:0] step_reg, cnt_reg, k_reg;
    logic          done_reg, fin_reg;
    logic [VW-1:0] j_reg, a_reg, entry_reg;
    logic          sv_v_reg;
    logic [IW-1:0] sv_i_reg;
    logic          m_valid_reg;
    prpg_pkg::out_item_t m_data_reg;

    logic [VW-1:0] rda_reg, rdb_reg, rds_reg;
    logic          rdm_reg;
    logic [IW-1:0] ra_addr;

    logic [LW-1:0] n_eff, p_eff;
    logic          div_start, div_done;
    logic [VW-1:0] div_rem;

    // Saturate length and partial count
    always_comb begin
        if (len_reg == '0) begin
            n_eff = LW'(1);
        end else if (len_reg > LW'(DEPTH)) begin
            n_eff = LW'(DEPTH);
        end else begin
            n_eff = len_reg;
        end
        p_eff = (pcnt_reg > n_eff) ? n_eff : pcnt_reg;
    end

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;
    assign div_start = s_valid && s_ready && (s_data.operation == prpg_pkg::OP_SHUFFLE)
                       && !done_reg && (step_reg < n_eff);

    prpg_mod u_mod (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (s_data.random_value),
        .divisor   (n_eff),
        .done      (div_done),
        .remainder (div_rem)
    );

    // Select table read address of port A
    always_comb begin
        case (state_reg)
            ST_IDLE: ra_addr = s_data.read_index;
            ST_SWRD: ra_addr = step_reg[IW-1:0];
            default: ra_addr = cnt_reg[IW-1:0];
        endcase
    end

    // Table memory: two read ports, one write port
    always_ff @(posedge aclk) begin
        rda_reg <= table_mem[ra_addr];
        rdb_reg <= table_mem[j_reg];
        case (state_reg)
            ST_ID: begin
                if (cnt_reg < n_eff) table_mem[cnt_reg[IW-1:0]] <= VW'(cnt_reg);
            end
            ST_SWWA: table_mem[step_reg[IW-1:0]] <= rdb_reg;
            ST_SWWB: table_mem[j_reg] <= a_reg;
            ST_SCWR: begin
                if (rdm_reg && (k_reg < p_eff)) table_mem[cnt_reg[IW-1:0]] <= rds_reg;
            end
            default: ;
        endcase
    end

    // Saved prefix memory
    always_ff @(posedge aclk) begin
        rds_reg <= saved_mem[k_reg[IW-1:0]];
        if (state_reg == ST_SAVE && sv_v_reg) saved_mem[sv_i_reg] <= rda_reg;
    end

    // Value mark memory
    always_ff @(posedge aclk) begin
        rdm_reg <= marks_mem[cnt_reg[IW-1:0]];
        case (state_reg)
            ST_CLR:  marks_mem[cnt_reg[IW-1:0]] <= 1'b0;
            ST_SAVE: begin
                if (sv_v_reg) marks_mem[rda_reg] <= 1'b1;
            end
            ST_SCWR: marks_mem[cnt_reg[IW-1:0]] <= 1'b0;
            default: ;
        endcase
    end

    // Sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLR;
            cnt_reg     <= '0;
            step_reg    <= '0;
            done_reg    <= 1'b0;
            fin_reg     <= 1'b0;
            sv_v_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
            len_reg     <= LW'(1024);
            pcnt_reg    <= '0;
            pen_reg     <= 1'b0;
        end else begin
            // Take configuration writes
            if (cfg_valid) begin
                case (cfg_index)
                    prpg_pkg::REG_PERM_LENGTH:    len_reg  <= cfg_data;
                    prpg_pkg::REG_PARTIAL_COUNT:  pcnt_reg <= cfg_data;
                    prpg_pkg::REG_PARTIAL_ENABLE: pen_reg  <= cfg_data[0];
                    default: ;
                endcase
            end
            // Drop delivered result; the response state reloads it itself
            if (m_valid_reg && m_ready && (state_reg != ST_RESP)) m_valid_reg <= 1'b0;

            case (state_reg)
                ST_CLR: begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == LW'(DEPTH - 1)) state_reg <= ST_IDLE;
                end
                ST_IDLE: begin
                    if (s_valid) begin
                        entry_reg <= '0;
                        case (s_data.operation)
                            prpg_pkg::OP_BEGIN: begin
                                cnt_reg   <= '0;
                                fin_reg   <= 1'b0;
                                step_reg  <= '0;
                                done_reg  <= 1'b0;
                                state_reg <= ST_ID;
                            end
                            prpg_pkg::OP_SHUFFLE: begin
                                if (done_reg) begin
                                    state_reg <= ST_RESP;
                                end else if (step_reg < n_eff) begin
                                    state_reg <= ST_DIV;
                                end else begin
                                    state_reg <= ST_FIN;
                                end
                            end
                            prpg_pkg::OP_READ: state_reg <= ST_RDW;
                            default: state_reg <= ST_RESP;
                        endcase
                    end
                end
                ST_ID: begin
                    if (cnt_reg < n_eff) begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end else if (fin_reg) begin
                        cnt_reg   <= '0;
                        k_reg     <= '0;
                        state_reg <= ST_SCRD;
                    end else begin
                        state_reg <= ST_RESP;
                    end
                end
                ST_DIV: begin
                    if (div_done) begin
                        j_reg     <= div_rem;
                        state_reg <= ST_SWRD;
                    end
                end
                ST_SWRD: state_reg <= ST_SWWA;
                ST_SWWA: begin
                    a_reg     <= rda_reg;
                    state_reg <= ST_SWWB;
                end
                ST_SWWB: begin
                    step_reg  <= step_reg + 1'b1;
                    state_reg <= ST_CHK;
                end
                ST_CHK: state_reg <= (step_reg >= n_eff) ? ST_FIN : ST_RESP;
                ST_FIN: begin
                    if (pen_reg) begin
                        cnt_reg   <= '0;
                        sv_v_reg  <= 1'b0;
                        state_reg <= ST_SAVE;
                    end else begin
                        done_reg  <= 1'b1;
                        state_reg <= ST_RESP;
                    end
                end
                ST_SAVE: begin
                    // Stream prefix reads, store each entry in the cycle after its read
                    sv_v_reg <= (cnt_reg < p_eff);
                    sv_i_reg <= cnt_reg[IW-1:0];
                    if (cnt_reg < p_eff) begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end else if (!sv_v_reg) begin
                        cnt_reg   <= '0;
                        fin_reg   <= 1'b1;
                        state_reg <= ST_ID;
                    end
                end
                ST_SCRD: begin
                    // Scan every position: marked values may lie above the length
                    if (cnt_reg < LW'(DEPTH)) begin
                        state_reg <= ST_SCWR;
                    end else begin
                        done_reg  <= 1'b1;
                        state_reg <= ST_RESP;
                    end
                end
                ST_SCWR: begin
                    if (rdm_reg && (k_reg < p_eff)) k_reg <= k_reg + 1'b1;
                    cnt_reg   <= cnt_reg + 1'b1;
                    state_reg <= ST_SCRD;
                end
                ST_RDW: begin
                    entry_reg <= rda_reg;
                    state_reg <= ST_RESP;
                end
                ST_RESP: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg             <= 1'b1;
                        m_data_reg.entry_value  <= entry_reg;
                        m_data_reg.shuffle_done <= done_reg;
                        state_reg               <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

[sv/prpg_checker.sv]
// Port-level checker of the permutation generator, bound to the top level.
`timescale 1ns / 1ps

module prpg_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input logic                m_valid,
    input logic                m_ready,
    input prpg_pkg::out_item_t m_data
);

    // Stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // One item at a time
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken while busy");

    // Clearing pass after reset blocks input
    a_clear: assert property (@(posedge aclk)
        !aresetn |=> !s_ready && !m_valid)
        else $error("input open during clearing pass");

endmodule

bind partial_random_permutation_gen_core prpg_checker u_prpg_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
